@@ sv/lsam_pkg.sv @@
// Shared types and constants for the load/store align-and-merge pipeline.
// Used by every stage module and the top level; depends on nothing.
package lsam_pkg;

  typedef enum logic [3:0] {
    KIND_LB  = 4'd0,
    KIND_LBU = 4'd1,
    KIND_LH  = 4'd2,
    KIND_LHU = 4'd3,
    KIND_LW  = 4'd4,
    KIND_LWL = 4'd5,
    KIND_LWR = 4'd6,
    KIND_LUI = 4'd7,
    KIND_SB  = 4'd8,
    KIND_SH  = 4'd9,
    KIND_SW  = 4'd10,
    KIND_SWL = 4'd11,
    KIND_SWR = 4'd12
  } kind_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [31:0] MASK_LO24  = 32'h00FF_FFFF;
  localparam logic [31:0] MASK_HI24  = 32'hFFFF_FF00;
  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;
  localparam logic [4:0]  SHIFT_TOP  = 5'd24;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] base;
    logic [15:0] offset;
    logic [31:0] rt_value;
    logic [31:0] mem_data;
    logic        fault;
  } req_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] ea;
    logic [15:0] offset;
    logic [31:0] rt_value;
    logic [31:0] mem_data;
    logic        fault;
  } addr_item_t;

  typedef struct packed {
    logic [31:0] access_address;
    logic [1:0]  access_size;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] store_data;
    logic        reg_write;
    logic [31:0] reg_value;
    logic        kill;
  } merge_item_t;

  typedef struct packed {
    logic [31:0] access_address;
    logic [1:0]  access_size;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] store_data;
    logic        reg_write;
    logic [31:0] reg_value;
  } result_t;

endpackage

@@ sv/lsam_addr_stage.sv @@
// First pipeline stage: registers the request and forms the effective address.
// Depends on lsam_pkg.
module lsam_addr_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lsam_pkg::req_t       in_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lsam_pkg::addr_item_t out_item
);

  logic                 valid;
  lsam_pkg::addr_item_t item;
  lsam_pkg::addr_item_t item_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    item_next.kind     = in_req.kind;
    item_next.ea       = in_req.base + {{16{in_req.offset[15]}}, in_req.offset};
    item_next.offset   = in_req.offset;
    item_next.rt_value = in_req.rt_value;
    item_next.mem_data = in_req.mem_data;
    item_next.fault    = in_req.fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

@@ sv/lsam_merge_stage.sv @@
// Second pipeline stage: decodes the operation, aligns loads and merges partial words.
// Depends on lsam_pkg.
module lsam_merge_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lsam_pkg::addr_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lsam_pkg::merge_item_t out_item
);

  logic                  valid;
  lsam_pkg::merge_item_t item;
  lsam_pkg::merge_item_t item_next;
  logic [4:0]            sh;
  logic [4:0]            sh_inv;
  logic [31:0]           aligned;
  logic [31:0]           rt;
  logic [31:0]           mem;

  assign in_ready = !valid || out_ready;

  always_comb begin
    sh      = {in_item.ea[1:0], 3'b000};
    sh_inv  = lsam_pkg::SHIFT_TOP - sh;
    aligned = in_item.ea & lsam_pkg::ALIGN_MASK;
    rt      = in_item.rt_value;
    mem     = in_item.mem_data;

    item_next.access_address = in_item.ea;
    item_next.access_size    = lsam_pkg::SIZE_BYTE;
    item_next.mem_read       = 1'b0;
    item_next.mem_write      = 1'b0;
    item_next.store_data     = '0;
    item_next.reg_write      = 1'b0;
    item_next.reg_value      = '0;
    item_next.kill           = in_item.fault;

    unique case (lsam_pkg::kind_t'(in_item.kind))
      lsam_pkg::KIND_LB: begin
        item_next.mem_read  = 1'b1;
        item_next.reg_write = 1'b1;
        item_next.reg_value = {{24{mem[7]}}, mem[7:0]};
      end
      lsam_pkg::KIND_LBU: begin
        item_next.mem_read  = 1'b1;
        item_next.reg_write = 1'b1;
        item_next.reg_value = {24'h0, mem[7:0]};
      end
      lsam_pkg::KIND_LH: begin
        item_next.access_size = lsam_pkg::SIZE_HALF;
        item_next.mem_read    = 1'b1;
        item_next.reg_write   = 1'b1;
        item_next.reg_value   = {{16{mem[15]}}, mem[15:0]};
      end
      lsam_pkg::KIND_LHU: begin
        item_next.access_size = lsam_pkg::SIZE_HALF;
        item_next.mem_read    = 1'b1;
        item_next.reg_write   = 1'b1;
        item_next.reg_value   = {16'h0, mem[15:0]};
      end
      lsam_pkg::KIND_LW: begin
        item_next.access_size = lsam_pkg::SIZE_WORD;
        item_next.mem_read    = 1'b1;
        item_next.reg_write   = 1'b1;
        item_next.reg_value   = mem;
      end
      lsam_pkg::KIND_LWL: begin
        item_next.access_address = aligned;
        item_next.access_size    = lsam_pkg::SIZE_WORD;
        item_next.mem_read       = 1'b1;
        item_next.reg_write      = 1'b1;
        item_next.reg_value      = (rt & (lsam_pkg::MASK_LO24 >> sh)) | (mem << sh_inv);
      end
      lsam_pkg::KIND_LWR: begin
        item_next.access_address = aligned;
        item_next.access_size    = lsam_pkg::SIZE_WORD;
        item_next.mem_read       = 1'b1;
        item_next.reg_write      = 1'b1;
        item_next.reg_value      = (rt & (lsam_pkg::MASK_HI24 << sh_inv)) | (mem >> sh);
      end
      lsam_pkg::KIND_LUI: begin
        item_next.access_address = '0;
        item_next.reg_write      = 1'b1;
        item_next.reg_value      = {in_item.offset, 16'h0};
        item_next.kill           = 1'b0;
      end
      lsam_pkg::KIND_SB: begin
        item_next.mem_write  = 1'b1;
        item_next.store_data = {24'h0, rt[7:0]};
      end
      lsam_pkg::KIND_SH: begin
        item_next.access_size = lsam_pkg::SIZE_HALF;
        item_next.mem_write   = 1'b1;
        item_next.store_data  = {16'h0, rt[15:0]};
      end
      lsam_pkg::KIND_SW: begin
        item_next.access_size = lsam_pkg::SIZE_WORD;
        item_next.mem_write   = 1'b1;
        item_next.store_data  = rt;
      end
      lsam_pkg::KIND_SWL: begin
        item_next.access_address = aligned;
        item_next.access_size    = lsam_pkg::SIZE_WORD;
        item_next.mem_read       = 1'b1;
        item_next.mem_write      = 1'b1;
        item_next.store_data     = (rt >> sh_inv) | (mem & (lsam_pkg::MASK_HI24 << sh));
      end
      lsam_pkg::KIND_SWR: begin
        item_next.access_address = aligned;
        item_next.access_size    = lsam_pkg::SIZE_WORD;
        item_next.mem_read       = 1'b1;
        item_next.mem_write      = 1'b1;
        item_next.store_data     = (rt << sh) | (mem & (lsam_pkg::MASK_LO24 >> sh_inv));
      end
      default: begin
        item_next.kill = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

@@ sv/lsam_out_stage.sv @@
// Final pipeline stage: applies the translation fault and clears unused data.
// Holds the output register. Depends on lsam_pkg.
module lsam_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lsam_pkg::merge_item_t in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lsam_pkg::result_t     out_result
);

  logic              valid;
  lsam_pkg::result_t result;
  lsam_pkg::result_t result_next;
  logic              wr;
  logic              rw;

  assign in_ready = !valid || out_ready;

  always_comb begin
    wr = in_item.mem_write && !in_item.kill;
    rw = in_item.reg_write && !in_item.kill;
    result_next.access_address = in_item.access_address;
    result_next.access_size    = in_item.access_size;
    result_next.mem_read       = in_item.mem_read;
    result_next.mem_write      = wr;
    result_next.store_data     = wr ? in_item.store_data : '0;
    result_next.reg_write      = rw;
    result_next.reg_value      = rw ? in_item.reg_value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result <= result_next;
    end
  end

  assign out_valid  = valid;
  assign out_result = result;

endmodule

@@ sv/load_store_align_merge_core.sv @@
// Load/store align-and-merge core: three register stages (address, merge, output).
// Throughput: one request per cycle while out_ready is high; each stage advances whenever its successor
// has room, so a stall at the output holds every stage without loss.
// Reset: synchronous, active high; clears all stage valid bits.
// Depends on lsam_pkg, lsam_addr_stage, lsam_merge_stage and lsam_out_stage.
module load_store_align_merge_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  kind,
  input  logic [31:0] base,
  input  logic [15:0] offset,
  input  logic [31:0] rt_value,
  input  logic [31:0] mem_data,
  input  logic        fault,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] access_address,
  output logic [1:0]  access_size,
  output logic        mem_read,
  output logic        mem_write,
  output logic [31:0] store_data,
  output logic        reg_write,
  output logic [31:0] reg_value
);

  lsam_pkg::req_t        req;
  lsam_pkg::addr_item_t  a_item;
  lsam_pkg::merge_item_t m_item;
  lsam_pkg::result_t     result;
  logic                  a_valid;
  logic                  a_ready;
  logic                  m_valid;
  logic                  m_ready;

  always_comb begin
    req.kind     = kind;
    req.base     = base;
    req.offset   = offset;
    req.rt_value = rt_value;
    req.mem_data = mem_data;
    req.fault    = fault;
  end

  lsam_addr_stage u_addr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (req),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_item  (a_item)
  );

  lsam_merge_stage u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_item   (a_item),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_item  (m_item)
  );

  lsam_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (m_valid),
    .in_ready   (m_ready),
    .in_item    (m_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign access_address = result.access_address;
  assign access_size    = result.access_size;
  assign mem_read       = result.mem_read;
  assign mem_write      = result.mem_write;
  assign store_data     = result.store_data;
  assign reg_write      = result.reg_write;
  assign reg_value      = result.reg_value;

endmodule
